// ----- rtl/npp_pkg.sv -----
// shared types and constants of the nearest point pick and remove block
// depends on nothing; imported by the interfaces, the top level and npp_dist
`timescale 1ns / 1ps

package npp_pkg;

    // defaults for the top-level parameters
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 8;

    // fixed field widths on the channels
    localparam int PORT_COORD_W = 8;
    localparam int OPCODE_W     = 2;

    // a pick-nearest candidate must lie strictly below this squared distance
    localparam int DIST_LIMIT = 100000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_OFFER   = 2'd1,
        OP_NEAREST = 2'd2,
        OP_LAST    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LAST,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/npp_in_if.sv -----
// input channel of the nearest point pick and remove block
// depends on npp_pkg for the field widths
`timescale 1ns / 1ps

interface npp_in_if
    import npp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [PORT_COORD_W-1:0] pos_x;
    logic [PORT_COORD_W-1:0] pos_y;
    logic                    cell_marked;

    modport source (output valid, opcode, pos_x, pos_y, cell_marked, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, cell_marked, output ready);
endinterface

// ----- rtl/npp_out_if.sv -----
// result channel of the nearest point pick and remove block
// depends on npp_pkg; CNT_W sets the width of the point count
`timescale 1ns / 1ps

interface npp_out_if
    import npp_pkg::*;
#(
    parameter int CNT_W = $clog2(MAX_POINTS_DEF + 1)
) ();
    logic                    valid;
    logic                    ready;
    logic                    pick_valid;
    logic [PORT_COORD_W-1:0] pick_x;
    logic [PORT_COORD_W-1:0] pick_y;
    logic [CNT_W-1:0]        stored_count;
    logic                    table_full;

    modport source (output valid, pick_valid, pick_x, pick_y, stored_count, table_full,
                    input ready);
    modport sink   (input valid, pick_valid, pick_x, pick_y, stored_count, table_full,
                     output ready);
endinterface

// ----- rtl/nearest_point_pick_and_remove.sv -----
// top level of the nearest point pick and remove block: sequencer and table
// depends on npp_pkg, npp_in_if, npp_out_if, npp_ram and npp_dist
`timescale 1ns / 1ps

// Usage
// in_ch carries one command per transfer (opcode, pos_x, pos_y, cell_marked);
// out_ch returns exactly one result per command, in command order.
// Points sit in order in a single-port-pair memory of MAX_POINTS entries.
// One command is worked on at a time; in_ch.ready is high only when idle.
// Work per command, with n points stored:
//   clear, offer                  : no memory read
//   pick last                     : one memory read
//   pick nearest, nothing in reach: a scan of all n entries
//   pick nearest, entry k removed : the scan, then a shift of the n - 1 - k later entries
// The scan reads one entry a cycle through the two-stage distance unit,
// and the removal shifts later entries down one a cycle.
// Results wait in an output register; the next command is accepted while
// a result waits, and a finished command holds in its last state until
// the output register is free, so a stalled receiver stalls the block.
// Reset empties the table at once (count to zero); no clearing pass.

module nearest_point_pick_and_remove
    import npp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    npp_in_if.sink           in_ch,
    npp_out_if.source        out_ch
);

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int AW      = $clog2(MAX_POINTS);
    localparam int PT_W    = 2 * COORD_BITS;
    localparam int LIM_W   = $clog2(DIST_LIMIT + 1);
    localparam int DIST_W  = (2 * COORD_BITS + 1 > LIM_W) ? 2 * COORD_BITS + 1 : LIM_W;
    localparam int TAG_W   = AW + PT_W;
    localparam int XW      = (COORD_BITS > PORT_COORD_W) ? COORD_BITS : PORT_COORD_W;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [DIST_W-1:0]       best_reg, best_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    logic [PT_W-1:0]         best_pt_reg, best_pt_next;
    logic                    found_reg, found_next;
    logic [PT_W-1:0]         query_reg, query_next;
    logic                    res_valid_reg, res_valid_next;
    logic [PT_W-1:0]         res_pt_reg, res_pt_next;
    logic                    res_full_reg, res_full_next;
    logic                    rd_vld_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_pick_reg, out_pick_next;
    logic [PORT_COORD_W-1:0] out_x_reg, out_x_next;
    logic [PORT_COORD_W-1:0] out_y_reg, out_y_next;
    logic [CNT_W-1:0]        out_count_reg, out_count_next;
    logic                    out_full_reg, out_full_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [PT_W-1:0]         ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [PT_W-1:0]         ram_rdata;

    logic                    dist_in_valid;
    logic                    dist_valid;
    logic [DIST_W-1:0]       dist_val;
    logic [TAG_W-1:0]        dist_tag;
    logic                    dist_busy;

    logic                    in_xfer;
    logic [XW-1:0]           in_x_wide;
    logic [XW-1:0]           in_y_wide;
    logic [PT_W-1:0]         in_pt;
    logic [XW-1:0]           res_x_wide;
    logic [XW-1:0]           res_y_wide;
    logic                    scan_done;
    logic                    shift_done;
    logic                    out_free;

    // input coordinates kept in COORD_BITS bits, point packed as {x, y}
    assign in_x_wide = XW'(in_ch.pos_x);
    assign in_y_wide = XW'(in_ch.pos_y);
    assign in_pt     = {in_x_wide[COORD_BITS-1:0], in_y_wide[COORD_BITS-1:0]};
    assign res_x_wide = XW'(res_pt_reg[PT_W-1:COORD_BITS]);
    assign res_y_wide = XW'(res_pt_reg[COORD_BITS-1:0]);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid & in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // scan ends once every entry has been read and the distance unit drained
    assign scan_done  = (rd_idx_reg == count_reg) && !rd_vld_reg && !dist_busy;
    assign shift_done = (rd_idx_reg == count_reg) && !rd_vld_reg;

    // point table
    npp_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared distance unit
    assign dist_in_valid = rd_vld_reg && (state_reg == S_SCAN);

    npp_dist #(
        .COORD_BITS (COORD_BITS),
        .DIST_W     (DIST_W),
        .TAG_W      (TAG_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_in_valid),
        .pt_x      (ram_rdata[PT_W-1:COORD_BITS]),
        .pt_y      (ram_rdata[COORD_BITS-1:0]),
        .q_x       (query_reg[PT_W-1:COORD_BITS]),
        .q_y       (query_reg[COORD_BITS-1:0]),
        .tag_in    ({rd_addr_reg, ram_rdata}),
        .out_valid (dist_valid),
        .dist_sq   (dist_val),
        .tag_out   (dist_tag),
        .busy      (dist_busy)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (opcode_t'(in_ch.opcode))
                        OP_NEAREST: state_next = (count_reg == '0) ? S_EMIT : S_SCAN;
                        OP_LAST:    state_next = (count_reg == '0) ? S_EMIT : S_LAST;
                        default:    state_next = S_EMIT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = found_reg ? S_SHIFT : S_EMIT;
                end
            end
            S_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_LAST:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory control and result register
    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        best_pt_next   = best_pt_reg;
        found_next     = found_reg;
        query_next     = query_reg;
        res_valid_next = res_valid_reg;
        res_pt_next    = res_pt_reg;
        res_full_next  = res_full_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_addr_reg - AW'(1);
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg[AW-1:0];
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_pick_next  = out_pick_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    res_valid_next = 1'b0;
                    res_pt_next    = '0;
                    res_full_next  = 1'b0;
                    case (opcode_t'(in_ch.opcode))
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_OFFER:
                        begin
                            // append a marked cell, or flag it dropped when full
                            if (in_ch.cell_marked)
                            begin
                                if (count_reg < CNT_W'(MAX_POINTS))
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = count_reg[AW-1:0];
                                    ram_wdata  = in_pt;
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    res_full_next = 1'b1;
                                end
                            end
                        end
                        OP_NEAREST:
                        begin
                            query_next  = in_pt;
                            best_next   = DIST_W'(DIST_LIMIT);
                            found_next  = 1'b0;
                            rd_idx_next = '0;
                        end
                        OP_LAST:
                        begin
                            // read the newest entry
                            if (count_reg != '0)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(count_reg - CNT_W'(1));
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // stream entries into the distance unit, one a cycle
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                // keep the first strict minimum
                if (dist_valid && (dist_val < best_reg))
                begin
                    best_next     = dist_val;
                    best_idx_next = dist_tag[TAG_W-1:PT_W];
                    best_pt_next  = dist_tag[PT_W-1:0];
                    found_next    = 1'b1;
                end
                if (scan_done && found_reg)
                begin
                    res_valid_next = 1'b1;
                    res_pt_next    = best_pt_reg;
                    rd_idx_next    = CNT_W'(best_idx_reg) + CNT_W'(1);
                end
            end
            S_SHIFT:
            begin
                // read entry i and write it back to i - 1
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    ram_we = 1'b1;
                end
                if (shift_done)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_LAST:
            begin
                res_valid_next = 1'b1;
                res_pt_next    = ram_rdata;
                count_next     = count_reg - CNT_W'(1);
            end
            S_EMIT:
            begin
                // load the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pick_next  = res_valid_reg;
                    out_x_next     = res_x_wide[PORT_COORD_W-1:0];
                    out_y_next     = res_y_wide[PORT_COORD_W-1:0];
                    out_count_next = count_reg;
                    out_full_next  = res_full_reg;
                end
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= ram_re;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        rd_addr_reg   <= ram_raddr;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        best_pt_reg   <= best_pt_next;
        found_reg     <= found_next;
        query_reg     <= query_next;
        res_valid_reg <= res_valid_next;
        res_pt_reg    <= res_pt_next;
        res_full_reg  <= res_full_next;
        out_pick_reg  <= out_pick_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_count_reg <= out_count_next;
        out_full_reg  <= out_full_next;
    end

    // result channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pick_valid   = out_pick_reg;
    assign out_ch.pick_x       = out_x_reg;
    assign out_ch.pick_y       = out_y_reg;
    assign out_ch.stored_count = out_count_reg;
    assign out_ch.table_full   = out_full_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table size");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_SHIFT)) |-> (CNT_W'(ram_waddr) < count_reg))
        else $error("shift write outside stored entries");

    a_shift_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (found_reg && res_valid_reg))
        else $error("removal without a picked point");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("command transfer left the sequencer idle");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && (state_next != S_SCAN)) |-> !dist_busy)
        else $error("scan ended with distances in flight");

endmodule

// ----- rtl/npp_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module npp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/npp_dist.sv -----
// two-stage squared euclidean distance unit, shared by every scan step
// depends on npp_pkg; carries a tag alongside each distance
`timescale 1ns / 1ps

module npp_dist
    import npp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_W     = 17,
    parameter int TAG_W      = 26
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [COORD_BITS-1:0]   pt_x,
    input  logic [COORD_BITS-1:0]   pt_y,
    input  logic [COORD_BITS-1:0]   q_x,
    input  logic [COORD_BITS-1:0]   q_y,
    input  logic [TAG_W-1:0]        tag_in,
    output logic                    out_valid,
    output logic [DIST_W-1:0]       dist_sq,
    output logic [TAG_W-1:0]        tag_out,
    output logic                    busy
);

    localparam int SQ_W = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [TAG_W-1:0]      tag1_reg;
    logic                  v1_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [TAG_W-1:0]      tag2_reg;
    logic                  v2_reg;

    // absolute differences
    assign dx = (pt_x > q_x) ? (pt_x - q_x) : (q_x - pt_x);
    assign dy = (pt_y > q_y) ? (pt_y - q_y) : (q_y - pt_y);

    // stage one: squares
    always_ff @(posedge clk)
    begin
        sqx_reg  <= SQ_W'(dx) * SQ_W'(dx);
        sqy_reg  <= SQ_W'(dy) * SQ_W'(dy);
        tag1_reg <= tag_in;
    end

    // stage two: sum
    always_ff @(posedge clk)
    begin
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        tag2_reg <= tag1_reg;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign dist_sq   = dist_reg;
    assign tag_out   = tag2_reg;
    assign busy      = v1_reg | v2_reg;

endmodule
